// ===== rtl/cils_pkg.sv =====
// ----------------------------------------------------------------------------
// cils_pkg
// Types and character codes shared by the integer literal scanner.
// ----------------------------------------------------------------------------
package cils_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS,
    PH_AFTER_U,
    PH_AFTER_L
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

  typedef enum logic [2:0] {
    CL_INT,
    CL_UINT,
    CL_LONG,
    CL_ULONG,
    CL_LLONG,
    CL_FLOAT
  } class_t;

  typedef struct packed {
    phase_t      phase;
    radix_t      radix;
    logic [63:0] acc;
    logic        ovf;
    class_t      cls;
  } scan_state_t;

  typedef struct packed {
    class_t      cls;
    logic [31:0] value_low;
    logic        too_big;
    logic        overflow;
    logic        char_taken;
  } scan_result_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_UP_U  = 8'h55;
  localparam logic [7:0] CH_LO_L  = 8'h6c;
  localparam logic [7:0] CH_UP_L  = 8'h4c;

  localparam logic [3:0] HEX_LETTER_BIAS = 4'd9;

endpackage

// ===== rtl/cils_step.sv =====
// ----------------------------------------------------------------------------
// cils_step
// Next-state and result logic for one character of a numeric literal.
// ----------------------------------------------------------------------------
module cils_step (
  input  logic [7:0]            ch,
  input  logic                  first,
  input  cils_pkg::scan_state_t st,
  output cils_pkg::scan_state_t st_nxt,
  output logic                  emit,
  output cils_pkg::scan_result_t res
);
  import cils_pkg::*;

  logic        is_dec;
  logic        is_hex_letter;
  logic        dig_ok;
  logic [3:0]  dig_val;
  logic [67:0] acc_ext;
  logic [67:0] prod;
  logic [67:0] sum;
  logic        is_u;
  logic        is_l;
  logic        is_float_mark;
  logic        do_end;
  logic        with_val;
  logic        taken;
  class_t      cls;

  assign is_dec        = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_hex_letter = ((ch >= CH_LO_A) && (ch <= CH_LO_F)) ||
                         ((ch >= CH_UP_A) && (ch <= CH_UP_F));
  assign dig_ok        = (is_dec && !((st.radix == RX_OCT) && ch[3])) ||
                         ((st.radix == RX_HEX) && is_hex_letter);
  assign dig_val       = is_dec ? ch[3:0] : ch[3:0] + HEX_LETTER_BIAS;
  assign is_u          = (ch == CH_LO_U) || (ch == CH_UP_U);
  assign is_l          = (ch == CH_LO_L) || (ch == CH_UP_L);
  assign is_float_mark = (ch == CH_DOT) || (ch == CH_LO_E) || (ch == CH_UP_E);

  assign acc_ext = {4'b0, st.acc};

  always_comb begin
    unique case (st.radix)
      RX_HEX:  prod = acc_ext << 4;
      RX_OCT:  prod = acc_ext << 3;
      default: prod = (acc_ext << 3) + (acc_ext << 1);
    endcase
  end

  assign sum = prod + {64'b0, dig_val};

  always_comb begin
    st_nxt   = st;
    emit     = 1'b0;
    cls      = CL_INT;
    with_val = 1'b0;
    taken    = 1'b0;
    do_end   = 1'b0;
    if (first) begin
      st_nxt.acc   = '0;
      st_nxt.ovf   = 1'b0;
      st_nxt.cls   = CL_INT;
      st_nxt.radix = RX_DEC;
      if (ch == CH_ZERO) begin
        st_nxt.radix = RX_OCT;
        st_nxt.phase = PH_ZERO;
      end else if (ch >= CH_ONE && ch <= CH_NINE) begin
        st_nxt.acc   = {60'b0, ch[3:0]};
        st_nxt.phase = PH_DIGITS;
      end else if (ch == CH_DOT) begin
        emit  = 1'b1;
        cls   = CL_FLOAT;
        taken = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end else begin
      unique case (st.phase)
        PH_ZERO: begin
          if (ch == CH_LO_X || ch == CH_UP_X) begin
            st_nxt.radix = RX_HEX;
            st_nxt.phase = PH_HEXPFX;
          end else if (dig_ok) begin
            st_nxt.acc   = sum[63:0];
            st_nxt.ovf   = st.ovf | (|sum[67:64]);
            st_nxt.phase = PH_DIGITS;
          end else begin
            do_end = 1'b1;
          end
        end
        PH_HEXPFX: begin
          if (dig_ok) begin
            st_nxt.acc   = sum[63:0];
            st_nxt.ovf   = st.ovf | (|sum[67:64]);
            st_nxt.phase = PH_DIGITS;
          end else begin
            emit = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (dig_ok) begin
            st_nxt.acc = sum[63:0];
            st_nxt.ovf = st.ovf | (|sum[67:64]);
          end else begin
            do_end = 1'b1;
          end
        end
        PH_AFTER_U: begin
          if (is_l) begin
            st_nxt.cls   = CL_ULONG;
            st_nxt.phase = PH_AFTER_L;
          end else begin
            emit     = 1'b1;
            cls      = CL_UINT;
            with_val = 1'b1;
          end
        end
        PH_AFTER_L: begin
          emit     = 1'b1;
          with_val = 1'b1;
          if (is_l) begin
            cls   = CL_LLONG;
            taken = 1'b1;
          end else begin
            cls = st.cls;
          end
        end
        default: st_nxt.phase = PH_IDLE;
      endcase
      if (do_end) begin
        priority if (st.radix != RX_HEX && is_float_mark) begin
          emit  = 1'b1;
          cls   = CL_FLOAT;
          taken = 1'b1;
        end else if (is_u) begin
          st_nxt.cls   = CL_UINT;
          st_nxt.phase = PH_AFTER_U;
        end else if (is_l) begin
          st_nxt.cls   = CL_LONG;
          st_nxt.phase = PH_AFTER_L;
        end else begin
          emit     = 1'b1;
          with_val = 1'b1;
        end
      end
    end
    if (emit) begin
      st_nxt.phase = PH_IDLE;
    end
  end

  assign res.cls        = cls;
  assign res.value_low  = with_val ? st.acc[31:0] : 32'b0;
  assign res.overflow   = with_val & st.ovf;
  assign res.too_big    = with_val & (st.ovf | (|st.acc[63:32]));
  assign res.char_taken = taken;

endmodule

// ===== rtl/c_integer_literal_scanner.sv =====
// ----------------------------------------------------------------------------
// c_integer_literal_scanner
// Scans a C integer literal one character per item and reports its class,
// low value word and range flags when the literal ends.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | in_character[7:0], in_first_char
//  out     | out_valid/out_ready| out_token_class[2:0], out_value_low[31:0],
//          |                    | out_too_big, out_overflow, out_char_taken
//
//  One item per cycle sustained, unless an item that ends a literal waits for out_ready.
//  The scan step sits between the input register and the result register.
//  Reset (rst_n low, synchronous) empties both registers and idles the scanner.
//  An item with no result advances even while a result waits; an item that
//  ends a literal holds in the input register until the result register frees.
// ----------------------------------------------------------------------------
module c_integer_literal_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_first_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_class,
  output logic [31:0] out_value_low,
  output logic        out_too_big,
  output logic        out_overflow,
  output logic        out_char_taken
);
  import cils_pkg::*;

  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   in_char_r;
  logic         in_first_r;
  scan_state_t  state_r;
  scan_state_t  state_nxt;
  logic         out_valid_r, out_valid_nxt;
  scan_result_t out_r;
  scan_result_t step_res;
  logic         step_emit;
  logic         fire;
  logic         in_take;

  cils_step u_step (
    .ch     (in_char_r),
    .first  (in_first_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .emit   (step_emit),
    .res    (step_res)
  );

  assign fire     = in_valid_r && (!step_emit || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire && step_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r.phase <= PH_IDLE;
      state_r.radix <= RX_DEC;
      state_r.acc   <= '0;
      state_r.ovf   <= 1'b0;
      state_r.cls   <= CL_INT;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_char_r  <= in_character;
      in_first_r <= in_first_char;
    end
    if (fire && step_emit) begin
      out_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_class = out_r.cls;
  assign out_value_low   = out_r.value_low;
  assign out_too_big     = out_r.too_big;
  assign out_overflow    = out_r.overflow;
  assign out_char_taken  = out_r.char_taken;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire && step_emit && out_valid_r |-> out_ready)
    else $error("pending result overwritten");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    fire && step_emit |=> state_r.phase == PH_IDLE)
    else $error("scanner not idle after literal end");

  a_float_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.cls == CL_FLOAT |->
      out_r.value_low == 32'b0 && !out_r.too_big && !out_r.overflow)
    else $error("float result carries a value");

  a_ovf_implies_big: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.overflow |-> out_r.too_big)
    else $error("overflow without too_big");

endmodule

// ===== bench/cils_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cils_checker
// Watches both channels of the integer literal scanner, runs its own scan of
// every accepted character and compares each token that comes out, field by
// field, with the oldest predicted token.
// ----------------------------------------------------------------------------
module cils_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_first_char,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_token_class,
  input  logic [31:0] out_value_low,
  input  logic        out_too_big,
  input  logic        out_overflow,
  input  logic        out_char_taken,
  output int unsigned fail_count,
  output int unsigned tokens_due
);
  import cils_pkg::*;

  phase_t       scan_phase;
  radix_t       scan_radix;
  logic [63:0]  scan_acc;
  logic         scan_ovf;
  class_t       pending_class;
  scan_result_t expected_tokens[$];

  function automatic int digit_of(logic [7:0] c, radix_t rx);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (rx == RX_OCT && c > CH_ZERO + 7) return -1;
      return int'(c - CH_ZERO);
    end
    if (rx == RX_HEX) begin
      if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    end
    return -1;
  endfunction

  function automatic bit is_ell(logic [7:0] c);
    return c == CH_LO_L || c == CH_UP_L;
  endfunction

  task automatic push_digit(int d);
    logic [63:0] base;
    base = (scan_radix == RX_HEX) ? 64'd16 : (scan_radix == RX_OCT) ? 64'd8 : 64'd10;
    if (scan_acc > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / base) scan_ovf = 1'b1;
    scan_acc = scan_acc * base + 64'(d);
  endtask

  task automatic emit_token(class_t cls, bit with_value, bit taken);
    scan_result_t tok;
    logic [63:0]  v;
    logic         ov;
    v = with_value ? scan_acc : 64'd0;
    ov = with_value ? scan_ovf : 1'b0;
    tok.cls = cls;
    tok.value_low = v[31:0];
    tok.too_big = ov || (v[63:32] != 32'd0);
    tok.overflow = ov;
    tok.char_taken = taken;
    expected_tokens.insert(expected_tokens.size(), tok);
    scan_phase = PH_IDLE;
  endtask

  task automatic end_digits(logic [7:0] c);
    if (scan_radix != RX_HEX && (c == CH_DOT || c == CH_LO_E || c == CH_UP_E)) begin
      emit_token(CL_FLOAT, 1'b0, 1'b1);
    end else if (c == CH_LO_U || c == CH_UP_U) begin
      pending_class = CL_UINT;
      scan_phase = PH_AFTER_U;
    end else if (is_ell(c)) begin
      pending_class = CL_LONG;
      scan_phase = PH_AFTER_L;
    end else begin
      emit_token(CL_INT, 1'b1, 1'b0);
    end
  endtask

  task automatic scan_char(logic [7:0] c, logic first);
    int d;
    if (first) begin
      scan_acc = 64'd0;
      scan_ovf = 1'b0;
      pending_class = CL_INT;
      scan_radix = RX_DEC;
      if (c == CH_ZERO) begin
        scan_radix = RX_OCT;
        scan_phase = PH_ZERO;
      end else if (c >= CH_ONE && c <= CH_NINE) begin
        scan_acc = 64'(c - CH_ZERO);
        scan_phase = PH_DIGITS;
      end else if (c == CH_DOT) begin
        emit_token(CL_FLOAT, 1'b0, 1'b1);
      end else begin
        emit_token(CL_INT, 1'b0, 1'b0);
      end
      return;
    end
    case (scan_phase)
      PH_ZERO: begin
        d = digit_of(c, RX_OCT);
        if (c == CH_LO_X || c == CH_UP_X) begin
          scan_radix = RX_HEX;
          scan_phase = PH_HEXPFX;
        end else if (d >= 0) begin
          push_digit(d);
          scan_phase = PH_DIGITS;
        end else begin
          end_digits(c);
        end
      end
      PH_HEXPFX: begin
        d = digit_of(c, RX_HEX);
        if (d >= 0) begin
          push_digit(d);
          scan_phase = PH_DIGITS;
        end else begin
          emit_token(CL_INT, 1'b0, 1'b0);
        end
      end
      PH_DIGITS: begin
        d = digit_of(c, scan_radix);
        if (d >= 0) push_digit(d);
        else end_digits(c);
      end
      PH_AFTER_U: begin
        if (is_ell(c)) begin
          pending_class = CL_ULONG;
          scan_phase = PH_AFTER_L;
        end else begin
          emit_token(CL_UINT, 1'b1, 1'b0);
        end
      end
      PH_AFTER_L: begin
        if (is_ell(c)) emit_token(CL_LLONG, 1'b1, 1'b1);
        else emit_token(pending_class, 1'b1, 1'b0);
      end
      default: scan_phase = PH_IDLE;
    endcase
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      scan_phase = PH_IDLE;
      scan_radix = RX_DEC;
      scan_acc = 64'd0;
      scan_ovf = 1'b0;
      pending_class = CL_INT;
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: token with none due: cls=%0d val=%h big=%b ovf=%b taken=%b",
                     $realtime, out_token_class, out_value_low, out_too_big,
                     out_overflow, out_char_taken);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_token_class != want.cls || out_value_low != want.value_low ||
              out_too_big != want.too_big || out_overflow != want.overflow ||
              out_char_taken != want.char_taken) begin
            if (fail_count < 10)
              $display("%0t: token mismatch exp cls=%0d val=%h big=%b ovf=%b taken=%b",
                       $realtime, want.cls, want.value_low, want.too_big,
                       want.overflow, want.char_taken,
                       " got cls=%0d val=%h big=%b ovf=%b taken=%b",
                       out_token_class, out_value_low, out_too_big,
                       out_overflow, out_char_taken);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) scan_char(in_character, in_first_char);
    end
    tokens_due = expected_tokens.size();
  end

endmodule

// ===== bench/tb_c_integer_literal_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_integer_literal_scanner
// Feeds the integer literal scanner a short set of hand-picked literals, then
// random well-formed and broken literals in bursts, with the result side
// stalling on its own pattern and once holding off long enough to back up
// the input. The checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_c_integer_literal_scanner;
  import cils_pkg::*;

  localparam int CHAR_TARGET = 1050;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_character;
  logic        in_first_char;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_token_class;
  logic [31:0] out_value_low;
  logic        out_too_big;
  logic        out_overflow;
  logic        out_char_taken;

  int unsigned fail_count;
  int unsigned tokens_due;
  int unsigned chars_sent = 0;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  c_integer_literal_scanner uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_character   (in_character),
    .in_first_char  (in_first_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_class(out_token_class),
    .out_value_low  (out_value_low),
    .out_too_big    (out_too_big),
    .out_overflow   (out_overflow),
    .out_char_taken (out_char_taken)
  );

  cils_checker scan_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_character   (in_character),
    .in_first_char  (in_first_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_token_class(out_token_class),
    .out_value_low  (out_value_low),
    .out_too_big    (out_too_big),
    .out_overflow   (out_overflow),
    .out_char_taken (out_char_taken),
    .fail_count     (fail_count),
    .tokens_due     (tokens_due)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(logic [7:0] c, logic first, bit counted);
    bit taken;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_character <= c;
    in_first_char <= first;
    do begin
      @(posedge clk);
      taken = in_ready;
      @(negedge clk);
    end while (!taken);
    if (counted) chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0, 1'b1);
  endtask

  task automatic send_random_literal();
    logic [7:0] chars[$];
    string      stops;
    int         kind, ndig, suf, r, k;
    stops = " ,;)+";
    kind = $urandom_range(0, 9);
    ndig = ($urandom_range(0, 6) == 0) ? $urandom_range(12, 26) : $urandom_range(0, 6);
    if (kind < 4) begin
      chars.insert(chars.size(), 8'(CH_ONE + $urandom_range(0, 8)));
      repeat (ndig) chars.insert(chars.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
    end else if (kind < 6) begin
      chars.insert(chars.size(), CH_ZERO);
      repeat (ndig)
        chars.insert(chars.size(), 8'(CH_ZERO + $urandom_range(0, (kind == 5) ? 9 : 7)));
    end else if (kind < 9) begin
      chars.insert(chars.size(), CH_ZERO);
      chars.insert(chars.size(), $urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      repeat (ndig) begin
        r = $urandom_range(0, 21);
        chars.insert(chars.size(), r < 10 ? 8'(CH_ZERO + r) :
                                   r < 16 ? 8'(CH_LO_A + r - 10) : 8'(CH_UP_A + r - 16));
      end
    end else begin
      chars.insert(chars.size(), 8'($urandom_range(0, 255)));
    end
    suf = $urandom_range(0, 9);
    if (suf == 4 || suf == 6 || suf == 8)
      chars.insert(chars.size(), $urandom_range(0, 1) ? CH_LO_U : CH_UP_U);
    if (suf >= 5)
      chars.insert(chars.size(), $urandom_range(0, 1) ? CH_LO_L : CH_UP_L);
    if (suf == 7 || suf == 8)
      chars.insert(chars.size(), $urandom_range(0, 1) ? CH_LO_L : CH_UP_L);
    if (suf == 9)
      chars.insert(chars.size(), $urandom_range(0, 1) ? CH_LO_U : CH_UP_U);
    r = $urandom_range(0, 9);
    if (r < 5) chars.insert(chars.size(), stops[$urandom_range(0, 4)]);
    else if (r == 5) chars.insert(chars.size(), CH_DOT);
    else if (r == 6) chars.insert(chars.size(), $urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
    else if (r == 7) chars.insert(chars.size(), 8'($urandom_range(0, 255)));
    // break the literal now and then
    if ($urandom_range(0, 11) == 0) begin
      k = $urandom_range(1, chars.size());
      chars.insert(k, 8'($urandom_range(0, 255)));
    end
    foreach (chars[i]) send_char(chars[i], i == 0, 1'b1);
    // trailing noise, mostly seen while idle
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  initial begin : receiver
    int  mode, span, step;
    bit  held_off;
    held_off = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held_off && chars_sent >= 400) begin
        held_off = 1'b1;
        repeat (300) begin
          out_ready <= 1'b0;
          @(negedge clk);
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 200);
      for (step = 0; step < span; step++) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (step % 3 != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_character <= 8'h00;
    in_first_char <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_text("0E");
    send_text("7.");
    send_char(8'h00, 1'b1, 1'b1);
    send_text(".");
    send_text("0xG");
    send_text("0Xa9Ul;");
    send_text("08");
    send_text("12lu");
    send_text("3ULL");
    send_text("5");
    send_char(8'hFF, 1'b0, 1'b1);

    while (chars_sent < CHAR_TARGET) send_random_literal();

    in_valid <= 1'b0;
    while (tokens_due != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
